FILE: hw/rtl/sorted_priority_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion forms for the queue unit.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SPQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spq assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spq assertion failed");

`endif

FILE: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types and default sizes for the queue controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int CAPACITY_DEFAULT    = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic take;    // latch the incoming beat
      logic commit;  // apply the operation and load the result register
   } dp_cmd_type;

endpackage

`default_nettype wire

FILE: hw/rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Two-state sequencer: take one beat, then execute it into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output spq_pkg::dp_cmd_type     cmd
);

   spq_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign req_tready = (state_ff == spq_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd.take     = req_tvalid && req_tready;
      cmd.commit   = 1'b0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         spq_pkg::S_IDLE: begin
            if (cmd.take) begin
               state_in = spq_pkg::S_EXEC;
            end
         end
         spq_pkg::S_EXEC: begin
            // hold until the result register can be reloaded
            if (slot_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = spq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/spq_datapath.sv
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Row of compare-and-shift cells holding the values largest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath #(
   parameter  int CAPACITY    = spq_pkg::CAPACITY_DEFAULT,
   parameter  int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEFAULT,
   localparam int CNT_W       = $clog2(CAPACITY + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire spq_pkg::dp_cmd_type      cmd,
   input  wire logic                     req_opcode,
   input  wire logic [VALUE_WIDTH-1:0]   req_value,
   output logic      [VALUE_WIDTH-1:0]   removed_value,
   output logic      [VALUE_WIDTH-1:0]   head_value,
   output logic      [CNT_W-1:0]         fill_count,
   output logic                          is_empty,
   output spq_pkg::status_type           status
);

   spq_pkg::opcode_type            op_ff;
   logic signed [VALUE_WIDTH-1:0]  val_ff;
   logic signed [VALUE_WIDTH-1:0]  entry_ff [CAPACITY];
   logic signed [VALUE_WIDTH-1:0]  entry_in [CAPACITY];
   logic        [CAPACITY-1:0]     stay;
   logic        [CNT_W-1:0]        count_ff, count_in;
   logic                           wr_en;
   logic        [VALUE_WIDTH-1:0]  removed_in;
   spq_pkg::status_type            status_in;

   logic        [VALUE_WIDTH-1:0]  removed_ff, head_ff;
   logic        [CNT_W-1:0]        fill_ff;
   logic                           empty_ff;
   spq_pkg::status_type            status_ff;

   // Latch the accepted beat.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff  <= spq_pkg::opcode_type'(req_opcode);
         val_ff <= req_value;
      end
   end

   // Each cell either keeps its value, takes the new value, or takes its
   // upper neighbor's value; on remove every cell but the last takes its lower neighbor.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] ins_val;
      logic signed [VALUE_WIDTH-1:0] rem_val;

      assign stay[i] = (count_ff > CNT_W'(i)) && (entry_ff[i] > val_ff);

      if (i == 0) begin : g_first
         assign ins_val = stay[i] ? entry_ff[i] : val_ff;
      end else begin : g_rest
         assign ins_val = stay[i]   ? entry_ff[i] :
                          stay[i-1] ? val_ff      : entry_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign rem_val = entry_ff[i];
      end else begin : g_inner
         assign rem_val = entry_ff[i+1];
      end

      assign entry_in[i] = (op_ff == spq_pkg::OP_REMOVE) ? rem_val : ins_val;
   end

   always_comb begin
      status_in  = spq_pkg::ST_DONE;
      count_in   = count_ff;
      wr_en      = 1'b0;
      removed_in = '0;
      unique case (op_ff)
         spq_pkg::OP_INSERT: begin
            if (count_ff == CNT_W'(CAPACITY)) begin
               status_in = spq_pkg::ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         spq_pkg::OP_REMOVE: begin
            if (count_ff == '0) begin
               status_in = spq_pkg::ST_EMPTY;
            end else begin
               wr_en      = 1'b1;
               count_in   = count_ff - CNT_W'(1);
               removed_in = entry_ff[0];
            end
         end
         default: begin
            status_in = spq_pkg::ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         entry_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   // A rejected beat leaves the row alone, so report the current head then.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         removed_ff <= removed_in;
         head_ff    <= (count_in == '0) ? '0 :
                       wr_en            ? entry_in[0] : entry_ff[0];
         fill_ff    <= count_in;
         empty_ff   <= (count_in == '0);
         status_ff  <= status_in;
      end
   end

   assign removed_value = removed_ff;
   assign head_value    = head_ff;
   assign fill_count    = fill_ff;
   assign is_empty      = empty_ff;
   assign status        = status_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded queue of signed values kept largest first; insert and remove beats.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Contents
//  req_     in   tvalid / tready    tuser: opcode, tdata: value
//  rsp_     out  tvalid / tready    tuser: status, tdata: removed, head, count, empty
//
//  Each beat is accepted, then executed: every cell of the compare-and-shift
//  row compares against the new value and moves at once.
//  The execute cycle waits while the result register holds a beat not taken.
//  A new beat is accepted while a finished result still waits downstream.
//  Reset empties the queue by clearing the count; stored values need no
//  clearing pass since only the first count positions are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_priority_queue_unit_assert.svh"

module sorted_priority_queue_unit #(
   parameter  int CAPACITY    = spq_pkg::CAPACITY_DEFAULT,
   parameter  int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEFAULT,
   localparam int CNT_W       = $clog2(CAPACITY + 1),
   localparam int REQ_DW      = ((VALUE_WIDTH + 7) / 8) * 8,
   localparam int RSP_BITS    = 2 * VALUE_WIDTH + CNT_W + 1,
   localparam int RSP_DW      = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [REQ_DW-1:0] req_tdata,   // value
   input  wire logic [0:0]        req_tuser,   // opcode
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [RSP_DW-1:0] rsp_tdata,   // removed_value, head_value,
                                               // fill_count, is_empty
   output logic      [1:0]        rsp_tuser    // status
);

   // Bit positions of the response fields inside rsp_tdata.
   localparam int HEAD_LO  = VALUE_WIDTH;
   localparam int FILL_LO  = 2 * VALUE_WIDTH;
   localparam int EMPTY_AT = 2 * VALUE_WIDTH + CNT_W;

   spq_pkg::dp_cmd_type       cmd;
   logic [VALUE_WIDTH-1:0]    removed_value;
   logic [VALUE_WIDTH-1:0]    head_value;
   logic [CNT_W-1:0]          fill_count;
   logic                      is_empty;
   spq_pkg::status_type       status;

   // Sequencer: one beat in flight, result register toward the consumer.
   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Cell row, count and result register.
   spq_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_opcode    (req_tuser[0]),
      .req_value     (req_tdata[VALUE_WIDTH-1:0]),
      .removed_value (removed_value),
      .head_value    (head_value),
      .fill_count    (fill_count),
      .is_empty      (is_empty),
      .status        (status)
   );

   // Pack the response fields lowest first; zero the byte padding.
   always_comb begin
      rsp_tdata                         = '0;
      rsp_tdata[VALUE_WIDTH-1:0]        = removed_value;
      rsp_tdata[HEAD_LO +: VALUE_WIDTH] = head_value;
      rsp_tdata[FILL_LO +: CNT_W]       = fill_count;
      rsp_tdata[EMPTY_AT]               = is_empty;
   end

   assign rsp_tuser = status;

   // A beat accepted means no second beat until the first has executed.
   `SPQ_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

   // The empty flag agrees with the count carried alongside it.
   `SPQ_ASSERT_NOW(a_empty_matches_count, clock, reset, rsp_tvalid,
      rsp_tdata[EMPTY_AT] == (rsp_tdata[FILL_LO +: CNT_W] == '0))

   // A rejected insert reports a full queue.
   `SPQ_ASSERT_NOW(a_full_reject, clock, reset, rsp_tvalid && (rsp_tuser == spq_pkg::ST_FULL),
      rsp_tdata[FILL_LO +: CNT_W] == CNT_W'(CAPACITY))

   // A refused remove returns zero from an empty queue.
   `SPQ_ASSERT_NOW(a_empty_reject, clock, reset, rsp_tvalid && (rsp_tuser == spq_pkg::ST_EMPTY),
      (rsp_tdata[VALUE_WIDTH-1:0] == '0) && rsp_tdata[EMPTY_AT])

endmodule

`default_nettype wire
